@@ hdl/srwu_pkg.sv @@
// shared types and constants of the rmsprop weight update engine
package srwu_pkg;

    localparam int unsigned NumWeightsDef = 1024;

    localparam int unsigned IndexW  = 10;
    localparam int unsigned WeightW = 32;
    localparam int unsigned MsW     = 48;
    localparam int unsigned RateW   = 24;
    localparam int unsigned DecayW  = 16;
    localparam int unsigned CfgW    = 24;

    localparam logic [MsW-1:0] MsMax  = {MsW{1'b1}};
    localparam logic [MsW-1:0] EpsQ32 = 48'd4295;

    localparam logic        ModeRst  = 1'b1;
    localparam logic [23:0] RateRst  = 24'd167772;
    localparam logic [15:0] DecayRst = 16'd58982;

    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_GRAD = 2'd1;

    localparam logic [1:0] CFG_MODE  = 2'd0;
    localparam logic [1:0] CFG_RATE  = 2'd1;
    localparam logic [1:0] CFG_DECAY = 2'd2;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_FETCH,
        S_DECODE,
        S_MUL_NUM,
        S_SGD,
        S_MUL_P,
        S_MUL_A,
        S_MUL_B,
        S_MUL_C,
        S_MUL_D,
        S_SUM,
        S_SQ_INIT,
        S_SQRT,
        S_DIV_INIT,
        S_DIV,
        S_UPD,
        S_WB,
        S_DONE
    } t_state;

endpackage

@@ hdl/srwu_if.sv @@
// valid/ready channels for items and results
interface srwu_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [9:0]  index;
    logic signed [31:0] value;

    modport source (output valid, output op, output index, output value, input ready);
    modport sink   (input valid, input op, input index, input value, output ready);
endinterface

interface srwu_out_if;
    logic        valid;
    logic        ready;
    logic [9:0]  out_index;
    logic signed [31:0] weight;

    modport source (output valid, output out_index, output weight, input ready);
    modport sink   (input valid, input out_index, input weight, output ready);
endinterface

@@ hdl/srwu_ram.sv @@
// generic single write port ram with registered read
module srwu_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/sgd_rmsprop_weight_update_top.sv @@
// top level of the rmsprop / sgd weight update engine
// Optimizer step engine over NUM_WEIGHTS Q16.16 weights with one Q16.32 mean-square
// entry each. A word on i_item loads a weight (clearing its mean square), applies a
// gradient, or reads; every word gives one result word on o_result with the index and
// the weight held there afterwards (zero when the index is out of range). After reset
// the block sweeps the mean-square ram to zero, one entry per cycle, taking no word
// until the sweep ends. Items are handled one at a time, each through fetch and
// decode; then a load goes to write-back, a read or out of range index to done, and a
// gradient step through the multiplies, the update and write-back. Rmsprop shares one
// 32x32 multiplier over six steps and one compare-subtract unit that runs a 32-step
// square root and a 57-step restoring division. A finished result sits in an output
// register, so the next word is taken while the previous result waits. Configuration
// (mode, learn_rate, decay_rate) is written through i_cfg_we / i_cfg_index / i_cfg_data;
// the user must write it only while the block is idle; the block does not enforce this.
module sgd_rmsprop_weight_update_top
    import srwu_pkg::*;
#(
    parameter int unsigned NUM_WEIGHTS = NumWeightsDef
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_index,
    input  logic [CfgW-1:0]   i_cfg_data,
    srwu_in_if.sink           i_item,
    srwu_out_if.source        o_result
);

    localparam int unsigned AW = (NUM_WEIGHTS > 1) ? $clog2(NUM_WEIGHTS) : 1;
    localparam logic [16:0]   NumW  = 17'(NUM_WEIGHTS);
    localparam logic [AW-1:0] LastA = AW'(NUM_WEIGHTS - 1);

    // configuration
    logic              r_mode;
    logic [RateW-1:0]  r_lr;
    logic [DecayW-1:0] r_dec;

    // control
    t_state      r_state, n_state;
    logic [AW-1:0] r_clr, n_clr;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_ov, n_ov;

    // item and datapath
    logic [1:0]          r_op, n_op;
    logic [IndexW-1:0]   r_index, n_index;
    logic [WeightW-1:0]  r_value, n_value;
    logic                r_neg, n_neg;
    logic [31:0]         r_mag, n_mag;
    logic [63:0]         r_prod, n_prod;
    logic [55:0]         r_num, n_num;
    logic [16:0]         r_ph, n_ph;
    logic [MsW-1:0]      r_acc, n_acc;
    logic [31:0]         r_t2lo, n_t2lo;
    logic [MsW-1:0]      r_ms, n_ms;
    logic [63:0]         r_x, n_x;
    logic [34:0]         r_rem, n_rem;
    logic [31:0]         r_root, n_root;
    logic [56:0]         r_dvd, n_dvd;
    logic [WeightW-1:0]  r_res, n_res;
    logic [IndexW-1:0]   r_oidx, n_oidx;
    logic [WeightW-1:0]  r_ow, n_ow;

    // shared units
    logic [31:0] m_a, m_b;
    logic [63:0] mul_p;
    logic [34:0] cs_a, cs_b, cs_diff;
    logic        cs_ge;

    // rams
    logic [16:0]        idx_ext;
    logic [AW-1:0]      addr;
    logic               in_range;
    logic [WeightW-1:0] w_rd;
    logic [MsW-1:0]     ms_rd;
    logic               w_we, ms_we;
    logic [AW-1:0]      ms_waddr;
    logic [MsW-1:0]     ms_wdata;

    // scratch
    logic [16:0]        c_dec;
    logic [65:0]        t1w;
    logic [48:0]        t2;
    logic [49:0]        msum;
    logic signed [58:0] nw;

    assign idx_ext  = {7'd0, r_index};
    assign addr     = idx_ext[AW-1:0];
    assign in_range = idx_ext < NumW;

    assign mul_p   = m_a * m_b;
    assign cs_ge   = cs_a >= cs_b;
    assign cs_diff = cs_a - cs_b;

    assign c_dec = 17'h10000 - {1'b0, r_dec};

    srwu_ram #(.WIDTH(WeightW), .DEPTH(NUM_WEIGHTS)) u_wram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (addr),
        .i_wdata (r_res),
        .i_raddr (addr),
        .o_rdata (w_rd)
    );

    srwu_ram #(.WIDTH(MsW), .DEPTH(NUM_WEIGHTS)) u_msram (
        .i_clk   (i_clk),
        .i_we    (ms_we),
        .i_waddr (ms_waddr),
        .i_wdata (ms_wdata),
        .i_raddr (addr),
        .o_rdata (ms_rd)
    );

    assign w_we     = (r_state == S_WB);
    assign ms_we    = (r_state == S_WB) || (r_state == S_CLEAR);
    assign ms_waddr = (r_state == S_CLEAR) ? r_clr : addr;
    assign ms_wdata = (r_state == S_CLEAR) ? '0 : r_ms;

    assign i_item.ready      = (r_state == S_IDLE);
    assign o_result.valid     = r_ov;
    assign o_result.out_index = r_oidx;
    assign o_result.weight    = r_ow;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= ModeRst;
            r_lr   <= RateRst;
            r_dec  <= DecayRst;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MODE:  r_mode <= i_cfg_data[0];
                CFG_RATE:  r_lr   <= i_cfg_data[RateW-1:0];
                CFG_DECAY: r_dec  <= i_cfg_data[DecayW-1:0];
                default: ;
            endcase
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_cnt   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_cnt   <= n_cnt;
            r_ov    <= n_ov;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_index <= n_index;
        r_value <= n_value;
        r_neg   <= n_neg;
        r_mag   <= n_mag;
        r_prod  <= n_prod;
        r_num   <= n_num;
        r_ph    <= n_ph;
        r_acc   <= n_acc;
        r_t2lo  <= n_t2lo;
        r_ms    <= n_ms;
        r_x     <= n_x;
        r_rem   <= n_rem;
        r_root  <= n_root;
        r_dvd   <= n_dvd;
        r_res   <= n_res;
        r_oidx  <= n_oidx;
        r_ow    <= n_ow;
    end

    always_comb begin
        n_state = r_state;
        n_clr   = r_clr;
        n_cnt   = r_cnt;
        n_ov    = r_ov;
        n_op    = r_op;
        n_index = r_index;
        n_value = r_value;
        n_neg   = r_neg;
        n_mag   = r_mag;
        n_prod  = r_prod;
        n_num   = r_num;
        n_ph    = r_ph;
        n_acc   = r_acc;
        n_t2lo  = r_t2lo;
        n_ms    = r_ms;
        n_x     = r_x;
        n_rem   = r_rem;
        n_root  = r_root;
        n_dvd   = r_dvd;
        n_res   = r_res;
        n_oidx  = r_oidx;
        n_ow    = r_ow;
        m_a     = '0;
        m_b     = '0;
        cs_a    = '0;
        cs_b    = '0;
        t1w     = '0;
        t2      = '0;
        msum    = '0;
        nw      = '0;

        if (r_ov && o_result.ready) begin
            n_ov = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                if (r_clr == LastA) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + 1'b1;
                end
            end
            S_IDLE: begin
                if (i_item.valid) begin
                    n_op    = i_item.op;
                    n_index = i_item.index;
                    n_value = i_item.value;
                    n_neg   = i_item.value[31];
                    n_mag   = i_item.value[31] ? (32'd0 - i_item.value) : i_item.value;
                    n_state = S_FETCH;
                end
            end
            S_FETCH: n_state = S_DECODE;
            S_DECODE: begin
                if (!in_range) begin
                    n_res   = '0;
                    n_state = S_DONE;
                end else begin
                    case (r_op)
                        OP_LOAD: begin
                            n_res   = r_value;
                            n_ms    = '0;
                            n_state = S_WB;
                        end
                        OP_GRAD: n_state = S_MUL_NUM;
                        default: begin
                            n_res   = w_rd;
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_MUL_NUM: begin
                // rate times gradient magnitude
                m_a     = {8'd0, r_lr};
                m_b     = r_mag;
                n_prod  = mul_p;
                n_state = r_mode ? S_MUL_P : S_SGD;
            end
            S_SGD: begin
                n_dvd   = 57'((r_prod[55:0] + 56'h80_0000) >> 24);
                n_ms    = ms_rd;
                n_state = S_UPD;
            end
            S_MUL_P: begin
                n_num   = r_prod[55:0];
                m_a     = {15'd0, c_dec};
                m_b     = r_mag;
                n_prod  = mul_p;
                n_state = S_MUL_A;
            end
            S_MUL_A: begin
                // low half of p times magnitude
                n_ph    = r_prod[48:32];
                m_a     = r_prod[31:0];
                m_b     = r_mag;
                n_prod  = mul_p;
                n_state = S_MUL_B;
            end
            S_MUL_B: begin
                n_acc   = r_prod[63:16];
                m_a     = {15'd0, r_ph};
                m_b     = r_mag;
                n_prod  = mul_p;
                n_state = S_MUL_C;
            end
            S_MUL_C: begin
                // t1 = (p_hi*mag << 16) + (p_lo*mag >> 16), saturated
                t1w     = (66'(r_prod[48:0]) << 16) + 66'(r_acc);
                n_acc   = (t1w > 66'(MsMax)) ? MsMax : t1w[47:0];
                m_a     = {16'd0, r_dec};
                m_b     = ms_rd[31:0];
                n_prod  = mul_p;
                n_state = S_MUL_D;
            end
            S_MUL_D: begin
                n_t2lo  = r_prod[47:16];
                m_a     = {16'd0, r_dec};
                m_b     = {16'd0, ms_rd[47:32]};
                n_prod  = mul_p;
                n_state = S_SUM;
            end
            S_SUM: begin
                t2      = (49'(r_prod[31:0]) << 16) + 49'(r_t2lo);
                msum    = 50'(r_acc) + 50'(t2);
                n_ms    = (msum > 50'(MsMax)) ? MsMax : msum[47:0];
                n_state = S_SQ_INIT;
            end
            S_SQ_INIT: begin
                n_x     = (64'(r_ms) + 64'(EpsQ32)) << 14;
                n_rem   = '0;
                n_root  = '0;
                n_cnt   = 6'd31;
                n_state = S_SQRT;
            end
            S_SQRT: begin
                // one root bit per cycle
                cs_a = {1'b0, r_rem[31:0], r_x[63:62]};
                cs_b = {1'b0, r_root, 2'b01};
                if (cs_ge) begin
                    n_rem  = cs_diff;
                    n_root = {r_root[30:0], 1'b1};
                end else begin
                    n_rem  = cs_a;
                    n_root = {r_root[30:0], 1'b0};
                end
                n_x = r_x << 2;
                if (r_cnt == '0) begin
                    n_state = S_DIV_INIT;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_DIV_INIT: begin
                // round to nearest: add half the divisor
                n_dvd   = 57'(r_num) + 57'(r_root);
                n_rem   = '0;
                n_cnt   = 6'd56;
                n_state = S_DIV;
            end
            S_DIV: begin
                // one quotient bit per cycle, divisor is 2*root
                cs_a = {r_rem[33:0], r_dvd[56]};
                cs_b = {2'b00, r_root, 1'b0};
                n_rem = cs_ge ? cs_diff : cs_a;
                n_dvd = {r_dvd[55:0], cs_ge};
                if (r_cnt == '0) begin
                    n_state = S_UPD;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_UPD: begin
                nw = r_neg ? (59'(signed'(w_rd)) + signed'(59'(r_dvd)))
                           : (59'(signed'(w_rd)) - signed'(59'(r_dvd)));
                if (nw > 59'sh7FFF_FFFF) begin
                    n_res = 32'h7FFF_FFFF;
                end else if (nw < -59'sh8000_0000) begin
                    n_res = 32'h8000_0000;
                end else begin
                    n_res = nw[31:0];
                end
                n_state = S_WB;
            end
            S_WB: n_state = S_DONE;
            S_DONE: begin
                if (!r_ov || o_result.ready) begin
                    n_ov    = 1'b1;
                    n_oidx  = r_index;
                    n_ow    = r_res;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

`ifndef SYNTH
    a_accept_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item.valid && i_item.ready) |=> (r_state == S_FETCH))
        else $error("accepted word did not start a fetch");

    a_root_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV_INIT) |-> (r_root != '0))
        else $error("square root is zero before division");

    a_sqrt_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SQRT && r_cnt != '0) |=> (r_state == S_SQRT && r_cnt == $past(r_cnt) - 1'b1))
        else $error("square root step count broken");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !o_result.ready) |=> r_ov && $stable(r_ow))
        else $error("pending result overwritten");
`endif

endmodule

@@ verif/sgd_rmsprop_weight_update_top_tb.sv @@
// self-checking testbench of the rmsprop / sgd weight update engine
`timescale 1ns / 1ps

module sgd_rmsprop_weight_update_top_tb
    import srwu_pkg::*;
();

    localparam logic [1:0] OP_READ = 2'd2;
    localparam logic [1:0] OP_SPARE = 2'd3;

    // expected result word
    typedef struct packed {
        logic [IndexW-1:0]  out_index;
        logic [WeightW-1:0] weight;
    } t_result;

    // mirror of the engine: weights, mean squares and registers
    class weight_scoreboard;
        logic [WeightW-1:0] weights [NumWeightsDef];
        logic [MsW-1:0]     mean_sq [NumWeightsDef];
        bit                 written [NumWeightsDef];
        logic               mode;
        logic [RateW-1:0]   rate;
        logic [DecayW-1:0]  decay;
        t_result            pending[$];
        int                 errors;

        function new();
            mode = ModeRst;
            rate = RateRst;
            decay = DecayRst;
            errors = 0;
            foreach (mean_sq[i]) begin
                mean_sq[i] = '0;
                written[i] = 1'b0;
                weights[i] = '0;
            end
        endfunction

        function void set_reg(logic [1:0] idx, logic [CfgW-1:0] data);
            if (idx == CFG_MODE) mode = data[0];
            else if (idx == CFG_RATE) rate = data[RateW-1:0];
            else if (idx == CFG_DECAY) decay = data[DecayW-1:0];
        endfunction

        function logic [63:0] int_sqrt(logic [63:0] x);
            logic [63:0] res;
            logic [63:0] b;
            res = 0;
            b = 64'd1 << 62;
            while (b > x) b >>= 2;
            while (b != 0) begin
                if (x >= res + b) begin
                    x -= res + b;
                    res = (res >> 1) + b;
                end else begin
                    res >>= 1;
                end
                b >>= 2;
            end
            return res;
        endfunction

        function logic [MsW-1:0] next_mean_sq(logic [63:0] mag, logic [MsW-1:0] ms);
            logic [63:0] p;
            logic [63:0] t1;
            logic [63:0] t2;
            p = mag * (64'd65536 - decay);
            t1 = p * (mag >> 16) + ((p * (mag & 64'hFFFF)) >> 16);
            if (t1 > MsMax) t1 = MsMax;
            t2 = (64'(decay) * ms) >> 16;
            t1 += t2;
            if (t1 > MsMax) t1 = MsMax;
            return t1[MsW-1:0];
        endfunction

        // note an accepted word and queue its result
        function void note_item(logic [1:0] op, logic [IndexW-1:0] idx,
                                logic signed [31:0] val);
            logic [63:0] mag;
            logic [63:0] num;
            logic [63:0] delta;
            logic [63:0] den;
            logic signed [63:0] nw;
            t_result r;
            r.out_index = idx;
            r.weight = '0;
            if (op == OP_LOAD) begin
                weights[idx] = val;
                mean_sq[idx] = '0;
                written[idx] = 1'b1;
            end else if (op == OP_GRAD) begin
                mag = val < 0 ? 64'(-64'(val)) : 64'(val);
                num = 64'(rate) * mag;
                if (mode == 1'b0) begin
                    delta = (num + (64'd1 << 23)) >> 24;
                end else begin
                    mean_sq[idx] = next_mean_sq(mag, mean_sq[idx]);
                    den = int_sqrt((64'(mean_sq[idx]) + 64'(EpsQ32)) << 14) << 1;
                    delta = (num + (den >> 1)) / den;
                end
                nw = 64'(signed'(weights[idx]));
                nw = val < 0 ? nw + signed'(delta) : nw - signed'(delta);
                if (nw > 64'sd2147483647) nw = 64'sd2147483647;
                if (nw < -64'sd2147483648) nw = -64'sd2147483648;
                weights[idx] = nw[31:0];
            end
            r.weight = weights[idx];
            pending.push_back(r);
        endfunction

        function void check_result(logic [IndexW-1:0] idx, logic [WeightW-1:0] w);
            t_result e;
            if (pending.size() == 0) begin
                $error("unexpected result word index %0d weight %0h", idx, w);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (e.out_index !== idx) begin
                $error("out_index expected %0d actual %0d", e.out_index, idx);
                errors++;
            end
            if (e.weight !== w) begin
                $error("weight expected %0h actual %0h", e.weight, w);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [1:0] i_cfg_index;
    logic [CfgW-1:0] i_cfg_data;

    srwu_in_if  item_ch ();
    srwu_out_if result_ch ();

    sgd_rmsprop_weight_update_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_item      (item_ch.sink),
        .o_result    (result_ch.source)
    );

    weight_scoreboard board;
    int send_idle_pct;   // chance in percent that the sender skips a cycle
    int recv_idle_pct;   // chance in percent that the receiver stalls
    int hold_cycles;     // long receiver hold-off, counted by the receiver
    int quiet_cycles;    // cycles with no accepted word, for the watchdog

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // receiver: random stalls plus an optional long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            result_ch.ready <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            result_ch.ready <= 1'b0;
        end else begin
            result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // check every accepted result word, and note every accepted item word
    always @(posedge i_clk) begin
        if (i_rst_n && result_ch.valid && result_ch.ready)
            board.check_result(result_ch.out_index, result_ch.weight);
        if (i_rst_n && item_ch.valid && item_ch.ready)
            board.note_item(item_ch.op, item_ch.index, item_ch.value);
    end

    // watchdog on cycles in which no word moves on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (item_ch.valid && item_ch.ready)
                || (result_ch.valid && result_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles > 20000) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // offer one word, with random idle cycles before it, and wait for acceptance
    task automatic send_word(logic [1:0] op, logic [IndexW-1:0] idx, logic [31:0] val);
        while ($urandom_range(99) < send_idle_pct) begin
            item_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.op <= op;
        item_ch.index <= idx;
        item_ch.value <= val;
        @(posedge i_clk);
        while (!item_ch.ready) @(posedge i_clk);
    endtask

    task automatic drain();
        item_ch.valid <= 1'b0;
        // let the last accepted word reach the scoreboard first
        @(posedge i_clk);
        while (board.pending.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [CfgW-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        board.set_reg(idx, data);
    endtask

    function automatic logic [IndexW-1:0] pick_written();
        logic [IndexW-1:0] k;
        k = IndexW'($urandom_range(NumWeightsDef - 1));
        while (!board.written[k]) k = k + 1'b1;
        return k;
    endfunction

    // random gradient, mostly small, sometimes full range
    function automatic logic [31:0] rand_grad();
        case ($urandom_range(3))
            0: return $urandom;
            1: return 32'(signed'(16'($urandom)));
            default: return 32'(signed'(20'($urandom)));
        endcase
    endfunction

    // random phase: loads, gradient steps on loaded entries and reads
    task automatic random_phase(int count);
        int k;
        int sel;
        logic [IndexW-1:0] idx;
        for (k = 0; k < count; k++) begin
            sel = $urandom_range(99);
            if (sel < 15) begin
                idx = IndexW'($urandom_range(NumWeightsDef - 1));
                send_word(OP_LOAD, idx, $urandom);
            end else if (sel < 80) begin
                send_word(OP_GRAD, pick_written(), rand_grad());
            end else begin
                send_word(sel < 90 ? OP_READ : OP_SPARE, pick_written(), $urandom);
            end
        end
    endtask

    initial begin
        int k;
        board = new();
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = CFG_MODE;
        i_cfg_data = '0;
        item_ch.valid = 1'b0;
        item_ch.op = OP_LOAD;
        item_ch.index = '0;
        item_ch.value = '0;
        result_ch.ready = 1'b0;
        send_idle_pct = 28;
        recv_idle_pct = 74;
        hold_cycles = 0;
        quiet_cycles = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, every op, saturation, reset defaults
        send_word(OP_LOAD, 10'd0, 32'h7FFF_FFF0);
        send_word(OP_LOAD, 10'd1023, 32'h8000_0010);
        send_word(OP_GRAD, 10'd0, 32'h8000_0000);
        send_word(OP_GRAD, 10'd1023, 32'h7FFF_FFFF);
        send_word(OP_GRAD, 10'd0, 32'h0000_0000);
        send_word(OP_READ, 10'd1023, 32'hFFFF_FFFF);
        send_word(OP_SPARE, 10'd0, 32'h1234_5678);
        send_word(OP_LOAD, 10'd5, 32'h0001_0000);
        send_word(OP_GRAD, 10'd5, 32'h0000_0001);
        send_word(OP_GRAD, 10'd5, 32'hFFFF_FFFF);
        send_word(OP_LOAD, 10'd5, 32'h0000_0000);
        send_word(OP_READ, 10'd5, 32'h0);
        drain();

        write_reg(CFG_MODE, 24'd0);
        write_reg(CFG_RATE, 24'hFFFFFF);
        send_word(OP_GRAD, 10'd0, 32'h7FFF_FFFF);
        send_word(OP_GRAD, 10'd1023, 32'h8000_0000);
        send_word(OP_GRAD, 10'd5, 32'h0000_0001);
        drain();
        write_reg(CFG_RATE, 24'd0);
        send_word(OP_GRAD, 10'd5, 32'h1234_5678);
        drain();

        // mostly random items in sgd mode, mid rate
        write_reg(CFG_RATE, 24'd200000);
        for (k = 0; k < 64; k++) send_word(OP_LOAD, 10'($urandom), $urandom);
        random_phase(150);

        // long receiver hold-off while items keep coming
        hold_cycles = 600;
        random_phase(20);
        drain();

        write_reg(CFG_MODE, 24'd1);
        write_reg(CFG_DECAY, 24'd0);
        write_reg(CFG_RATE, 24'd1);
        random_phase(60);
        drain();
        write_reg(CFG_DECAY, 24'hFFFF);
        write_reg(CFG_RATE, 24'hFFFFFF);
        random_phase(100);

        send_idle_pct = 74;
        recv_idle_pct = 28;
        drain();
        write_reg(CFG_DECAY, 24'd58982);
        write_reg(CFG_RATE, 24'd167772);
        random_phase(180);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(CFG_MODE, 24'd0);
        random_phase(100);
        drain();
        write_reg(CFG_MODE, 24'd1);
        write_reg(CFG_DECAY, 24'd30000);
        random_phase(100);
        drain();

        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
